[rtl/rrr_pkg.sv]
// ----------------------------------------------------------------------------
// rrr_pkg
// Shared types and constants of the replay ring retransmit unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrr_pkg;

  // Command codes of an input word
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_RETX  = 1'b1;

  // Sequence width and the folded remainder unit: 16-bit digits
  localparam int SEQ_W     = 64;
  localparam int MOD_BITS  = 16;
  localparam int MOD_STEPS = SEQ_W / MOD_BITS;
  localparam int MOD_CW    = $clog2(2 * MOD_STEPS);

  // One stored tick; seq doubles as the slot tag (zero means empty)
  typedef struct packed {
    logic [63:0] seq;
    logic [31:0] symbol;
    logic [63:0] price_bits;
    logic [63:0] stamp;
  } tick_t;

endpackage

`default_nettype wire

[rtl/replay_ring_retransmit_unit.sv]
// ----------------------------------------------------------------------------
// replay_ring_retransmit_unit
// Store: slot is the low sequence bits with a power-of-two RING_DEPTH, else the
//   sequence remainder, folded in 16-bit digits; then the tick is written.
// Retransmit: clamp and range check (then the remainder when RING_DEPTH is not a
//   power of two), a read and a compare per scanned slot, then a flush; output stalls hold it.
// Reset: asynchronous; afterwards the ring is cleared slot by slot, input held off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module replay_ring_retransmit_unit #(
  parameter int RING_DEPTH = 16384,
  parameter int MAX_BURST  = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [63:0] tick_seq_i,
  input  wire logic [31:0] tick_symbol_i,
  input  wire logic [63:0] tick_price_bits_i,
  input  wire logic [63:0] tick_time_i,
  input  wire logic [63:0] range_start_i,
  input  wire logic [63:0] range_end_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      out_seq_o,
  output logic [31:0]      out_symbol_o,
  output logic [63:0]      out_price_bits_o,
  output logic [63:0]      out_time_o,
  output logic             last_o,
  output logic             truncated_o
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(MAX_BURST + 1);
  localparam bit IS_POW2 = (RING_DEPTH & (RING_DEPTH - 1)) == 0;
  localparam logic [AW-1:0] SLOT_MAX = AW'(RING_DEPTH - 1);
  localparam logic [63:0]   WIN_SPAN = 64'(RING_DEPTH - 1);
  localparam logic [CW-1:0] BURST_MAX = CW'(MAX_BURST);
  localparam logic [31:0]   DEPTH_W = 32'(RING_DEPTH);
  localparam logic [31:0]   MOD_RECIP = 32'(64'h1_0000_0000 / 64'(RING_DEPTH));
  localparam int            MOD_LAST_I = 2 * rrr_pkg::MOD_STEPS - 1;
  localparam logic [rrr_pkg::MOD_CW-1:0] MOD_LAST = MOD_LAST_I[rrr_pkg::MOD_CW-1:0];

  typedef enum logic [3:0] {
    S_CLR,     // post-reset clearing pass over the ring
    S_IDLE,
    S_MOD,     // folded remainder of a sequence by RING_DEPTH
    S_WR,      // write a stored tick
    S_CLAMP,   // clamp the low end of a request
    S_RANGE,   // reject empty ranges, start the slot lookup
    S_RD,      // read one slot
    S_CMP,     // compare tag, move replay words along
    S_FLUSH    // release the final pending word
  } state_e;

  state_e state_q;

  // ring memory: tag and payload in one entry
  rrr_pkg::tick_t mem [RING_DEPTH];
  rrr_pkg::tick_t rd_q;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  rrr_pkg::tick_t mem_wdata;
  logic           mem_re;

  logic [AW-1:0]  clr_q;
  logic [AW-1:0]  slot_q;
  logic           cmd_q;
  logic [63:0]    latest_q;
  rrr_pkg::tick_t wr_q;

  // request state
  logic [63:0]    start_q;
  logic [63:0]    winlo_q;
  logic [63:0]    hi_q;
  logic [63:0]    scan_seq_q;
  rrr_pkg::tick_t pend_q;
  logic           pend_vld_q;
  logic [CW-1:0]  cnt_q;

  // remainder unit
  logic [63:0]               mod_val_q;
  logic [AW-1:0]             mod_rem_q;
  logic [AW-1:0]             mod_rem_d;
  logic [rrr_pkg::MOD_CW-1:0] mod_cnt_q;
  logic [31:0]               mod_y;
  logic [63:0]               mod_prod_q;
  logic [63:0]               mod_prod_d;
  logic [31:0]               mod_diff;

  // output register
  logic           out_valid_q;
  rrr_pkg::tick_t out_q;
  logic           out_last_q;
  logic           out_trunc_q;

  logic out_free;
  logic out_push;
  logic hit;
  logic [63:0] lo_c;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign hit        = (rd_q.seq == scan_seq_q);
  assign in_stall_o = (state_q != S_IDLE);

  // Load the output register when a pending word is released
  assign out_push = out_free && pend_vld_q &&
                    (((state_q == S_CMP) && hit) || (state_q == S_FLUSH));

  // Low end of a request: the larger of start and window floor, never zero.
  always_comb begin
    lo_c = (start_q > winlo_q) ? start_q : winlo_q;
    if (lo_c == 64'd0) begin
      lo_c = 64'd1;
    end
  end

  // One 16-bit digit at a time: r = {r, digit} mod RING_DEPTH.
  // Estimate the quotient by reciprocal multiplication (low by at most one),
  // then fix up the remainder with one compare and subtract.
  always_comb begin
    mod_y = '0;
    mod_y[rrr_pkg::MOD_BITS +: AW] = mod_rem_q;
    mod_y[rrr_pkg::MOD_BITS-1:0]  = mod_val_q[63 -: rrr_pkg::MOD_BITS];
    mod_prod_d = 64'(mod_y) * 64'(MOD_RECIP);
    mod_diff   = mod_y - mod_prod_q[63:32] * DEPTH_W;
    mod_rem_d  = (mod_diff >= DEPTH_W) ? AW'(mod_diff - DEPTH_W) : AW'(mod_diff);
  end

  // Memory port control: clear pass or store write; read while scanning.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = wr_q;
    if (state_q == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == S_WR) begin
      mem_we = 1'b1;
    end
    mem_re = (state_q == S_RD);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[slot_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      slot_q      <= '0;
      cmd_q       <= rrr_pkg::CMD_STORE;
      latest_q    <= '0;
      wr_q        <= '0;
      start_q     <= '0;
      winlo_q     <= '0;
      hi_q        <= '0;
      scan_seq_q  <= '0;
      pend_q      <= '0;
      pend_vld_q  <= 1'b0;
      cnt_q       <= '0;
      mod_val_q   <= '0;
      mod_rem_q   <= '0;
      mod_cnt_q   <= '0;
      mod_prod_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      out_last_q  <= 1'b0;
      out_trunc_q <= 1'b0;
    end else begin
      // hold a stalled output word, drop it once taken, load on a push
      out_valid_q <= out_push || (out_valid_q && out_stall_i);

      case (state_q)
        S_CLR: begin
          if (clr_q == SLOT_MAX) begin
            state_q <= S_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end

        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q <= command_i;
            if (command_i == rrr_pkg::CMD_STORE) begin
              wr_q.seq        <= tick_seq_i;
              wr_q.symbol     <= tick_symbol_i;
              wr_q.price_bits <= tick_price_bits_i;
              wr_q.stamp      <= tick_time_i;
              if (IS_POW2) begin
                slot_q  <= tick_seq_i[AW-1:0];
                state_q <= S_WR;
              end else begin
                mod_val_q <= tick_seq_i;
                mod_rem_q <= '0;
                mod_cnt_q <= '0;
                state_q   <= S_MOD;
              end
            end else begin
              // clamp the top to the latest, and find the window floor
              start_q <= range_start_i;
              hi_q    <= (range_end_i > latest_q) ? latest_q : range_end_i;
              winlo_q <= (latest_q >= WIN_SPAN) ? (latest_q - WIN_SPAN) : 64'd0;
              state_q <= S_CLAMP;
            end
          end
        end

        S_MOD: begin
          mod_cnt_q <= mod_cnt_q + 1'b1;
          if (!mod_cnt_q[0]) begin
            // first half of a digit: register the reciprocal product
            mod_prod_q <= mod_prod_d;
          end else begin
            // second half: fix up the remainder and advance to the next digit
            mod_rem_q <= mod_rem_d;
            mod_val_q <= mod_val_q << rrr_pkg::MOD_BITS;
            if (mod_cnt_q == MOD_LAST) begin
              slot_q  <= mod_rem_d;
              state_q <= (cmd_q == rrr_pkg::CMD_STORE) ? S_WR : S_RD;
            end
          end
        end

        S_WR: begin
          latest_q <= wr_q.seq;
          state_q  <= S_IDLE;
        end

        S_CLAMP: begin
          scan_seq_q <= lo_c;
          state_q    <= S_RANGE;
        end

        S_RANGE: begin
          pend_vld_q <= 1'b0;
          cnt_q      <= '0;
          if (scan_seq_q > hi_q) begin
            state_q <= S_IDLE;
          end else if (IS_POW2) begin
            slot_q  <= scan_seq_q[AW-1:0];
            state_q <= S_RD;
          end else begin
            mod_val_q <= scan_seq_q;
            mod_rem_q <= '0;
            mod_cnt_q <= '0;
            state_q   <= S_MOD;
          end
        end

        S_RD: begin
          state_q <= S_CMP;
        end

        S_CMP: begin
          // a hit with a word already pending needs the output register
          if (!(hit && pend_vld_q && !out_free)) begin
            if (hit) begin
              if (!pend_vld_q) begin
                pend_q     <= rd_q;
                pend_vld_q <= 1'b1;
                cnt_q      <= CW'(1);
              end else if (cnt_q == BURST_MAX) begin
                // one more qualifying tick exists: close with truncation
                out_q       <= pend_q;
                out_last_q  <= 1'b1;
                out_trunc_q <= 1'b1;
                pend_vld_q  <= 1'b0;
                state_q     <= S_IDLE;
              end else begin
                out_q       <= pend_q;
                out_last_q  <= 1'b0;
                out_trunc_q <= 1'b0;
                pend_q      <= rd_q;
                cnt_q       <= cnt_q + 1'b1;
              end
            end
            if (!(hit && pend_vld_q && (cnt_q == BURST_MAX))) begin
              if (scan_seq_q == hi_q) begin
                state_q <= S_FLUSH;
              end else begin
                scan_seq_q <= scan_seq_q + 64'd1;
                slot_q     <= (slot_q == SLOT_MAX) ? '0 : slot_q + 1'b1;
                state_q    <= S_RD;
              end
            end
          end
        end

        S_FLUSH: begin
          if (!pend_vld_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_q       <= pend_q;
            out_last_q  <= 1'b1;
            out_trunc_q <= 1'b0;
            pend_vld_q  <= 1'b0;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_seq_o        = out_q.seq;
  assign out_symbol_o     = out_q.symbol;
  assign out_price_bits_o = out_q.price_bits;
  assign out_time_o       = out_q.stamp;
  assign last_o           = out_last_q;
  assign truncated_o      = out_trunc_q;

endmodule

`default_nettype wire

[rtl/rrr_checker.sv]
// ----------------------------------------------------------------------------
// rrr_checker
// Port-level checks of the replay ring retransmit unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        command_i,
  input wire logic [63:0] tick_seq_i,
  input wire logic [31:0] tick_symbol_i,
  input wire logic [63:0] tick_price_bits_i,
  input wire logic [63:0] tick_time_i,
  input wire logic [63:0] range_start_i,
  input wire logic [63:0] range_end_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] out_seq_o,
  input wire logic [31:0] out_symbol_o,
  input wire logic [63:0] out_price_bits_o,
  input wire logic [63:0] out_time_o,
  input wire logic        last_o,
  input wire logic        truncated_o
);

  // no word leaves during reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output word valid during reset");

  // truncation is flagged only on the closing word
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && truncated_o |-> last_o)
    else $error("truncated without last");

  // a word that is not last means the request is still running
  a_mid_burst_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input taken in the middle of a burst");

  // a store keeps the unit busy while it writes the ring
  a_store_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (command_i == rrr_pkg::CMD_STORE) |=> in_stall_o)
    else $error("store accepted without a write cycle");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_seq_o))
    else $error("stalled output word changed");

endmodule

bind replay_ring_retransmit_unit rrr_checker u_rrr_checker (.*);

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb - replay ring retransmit unit testbench
// Drives store and retransmit words into the unit and checks every replayed
// tick against a shadow ring kept in the bench. A short table of directed
// words opens the run. Feed-like random traffic follows in four idling phases,
// with a long output hold-off that backs the unit up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int HALF_PERIOD     = 5;
  localparam int RING_DEPTH      = 16384;
  localparam int MAX_BURST       = 64;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int HOLD_CYCLES     = 600;
  localparam int FROM_MODEL      = -1;  // take the expected replays from the shadow ring
  localparam logic [63:0] SEQ_TOP = '1;

  // One input word and one replayed tick as the bench sees them
  typedef struct packed {
    logic           cmd;
    rrr_pkg::tick_t tick;
    logic [63:0]    r_start;
    logic [63:0]    r_end;
  } feed_word_t;

  typedef struct packed {
    rrr_pkg::tick_t tick;
    logic           last;
    logic           trunc;
  } replay_t;

  // Directed row: n_typed is 0 or 1 typed replays, or FROM_MODEL
  typedef struct {
    feed_word_t     word;
    int             n_typed;
    rrr_pkg::tick_t typed_tick;
  } dir_row_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic        command_i         = rrr_pkg::CMD_STORE;
  logic [63:0] tick_seq_i        = '0;
  logic [31:0] tick_symbol_i     = '0;
  logic [63:0] tick_price_bits_i = '0;
  logic [63:0] tick_time_i       = '0;
  logic [63:0] range_start_i     = '0;
  logic [63:0] range_end_i       = '0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic [63:0] out_seq_o;
  logic [31:0] out_symbol_o;
  logic [63:0] out_price_bits_o;
  logic [63:0] out_time_o;
  logic        last_o;
  logic        truncated_o;

  // Shadow copy of the ring: the stored tick's seq is also its slot tag
  rrr_pkg::tick_t shadow_ring [RING_DEPTH];
  logic [63:0]    shadow_latest;

  replay_t  burst_replays[$];    // replays of the word just accepted
  replay_t  pending_replays[$];  // replays still owed by the unit, oldest first
  dir_row_t dir_rows[$];
  replay_t  due_replay;

  // Idling knobs, written by the stimulus process only
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_asks = 0;

  // Receiver-side hold-off bookkeeping, written by the receiver process only
  int hold_taken = 0;
  int hold_left  = 0;

  int store_cnt    = 0;
  int retx_cnt     = 0;
  int checked_cnt  = 0;
  int trunc_cnt    = 0;
  int mismatch_cnt = 0;

  replay_ring_retransmit_unit #(
    .RING_DEPTH(RING_DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .tick_seq_i       (tick_seq_i),
    .tick_symbol_i    (tick_symbol_i),
    .tick_price_bits_i(tick_price_bits_i),
    .tick_time_i      (tick_time_i),
    .range_start_i    (range_start_i),
    .range_end_i      (range_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_seq_o        (out_seq_o),
    .out_symbol_o     (out_symbol_o),
    .out_price_bits_o (out_price_bits_o),
    .out_time_o       (out_time_o),
    .last_o           (last_o),
    .truncated_o      (truncated_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow ring: apply one accepted word and collect the ticks it replays
  // ---------------------------------------------------------------------------
  function automatic void replay_for(input feed_word_t w);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] win_lo;
    logic [63:0] s;
    int          k;
    bit          more;
    replay_t     r;
    burst_replays.delete();
    // Store: overwrite the slot and move latest, even backwards
    if (w.cmd == rrr_pkg::CMD_STORE) begin
      k = int'(w.tick.seq % 64'(RING_DEPTH));
      shadow_ring[k] = w.tick;
      shadow_latest  = w.tick.seq;
      return;
    end
    // Retransmit: clip the range to [window start, latest], never below one
    lo = w.r_start;
    hi = (w.r_end > shadow_latest) ? shadow_latest : w.r_end;
    win_lo = (shadow_latest >= 64'(RING_DEPTH - 1)) ?
             shadow_latest - 64'(RING_DEPTH - 1) : '0;
    if (lo < win_lo) lo = win_lo;
    if (lo == '0) lo = 64'd1;
    if (lo > hi) return;
    more = 1'b0;
    s = lo;
    while (1'b1) begin
      k = int'(s % 64'(RING_DEPTH));
      if (shadow_ring[k].seq == s) begin
        // One more match past the burst limit only sets the truncation flag
        if (burst_replays.size() == MAX_BURST) begin
          more = 1'b1;
          break;
        end
        r.tick  = shadow_ring[k];
        r.last  = 1'b0;
        r.trunc = 1'b0;
        burst_replays.insert(burst_replays.size(), r);
      end
      if (s == hi) break;
      s = s + 64'd1;
    end
    // Flag the final replay of the burst
    if (burst_replays.size() != 0) begin
      burst_replays[burst_replays.size() - 1].last  = 1'b1;
      burst_replays[burst_replays.size() - 1].trunc = more;
    end
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic rrr_pkg::tick_t rand_tick(input logic [63:0] seq);
    rrr_pkg::tick_t t;
    t.seq        = seq;
    t.symbol     = $urandom;
    t.price_bits = rand64();
    t.stamp      = rand64();
    return t;
  endfunction

  // Store word with junk in the ignored range fields
  function automatic feed_word_t store_word(input logic [63:0] seq);
    feed_word_t w;
    w.cmd     = rrr_pkg::CMD_STORE;
    w.tick    = rand_tick(seq);
    w.r_start = rand64();
    w.r_end   = rand64();
    return w;
  endfunction

  // Retransmit word with junk in the ignored tick fields
  function automatic feed_word_t retx_word(input logic [63:0] rs, input logic [63:0] re);
    feed_word_t w;
    w.cmd     = rrr_pkg::CMD_RETX;
    w.tick    = rand_tick(rand64());
    w.r_start = rs;
    w.r_end   = re;
    return w;
  endfunction

  function automatic void add_row(input logic cmd, input rrr_pkg::tick_t t,
                                  input logic [63:0] rs, input logic [63:0] re,
                                  input int n_typed, input rrr_pkg::tick_t typed_tick);
    dir_row_t row;
    row.word.cmd     = cmd;
    row.word.tick    = t;
    row.word.r_start = rs;
    row.word.r_end   = re;
    row.n_typed      = n_typed;
    row.typed_tick   = typed_tick;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // ---------------------------------------------------------------------------
  // Offer one word, hold it until taken, then queue the replays it owes.
  // Enter and leave at a rising edge; valid stays high into the next call.
  // ---------------------------------------------------------------------------
  task automatic issue_word(input feed_word_t w, input int n_typed,
                            input rrr_pkg::tick_t typed_tick);
    replay_t r;
    // Idle the input for a random number of cycles
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    command_i         <= w.cmd;
    tick_seq_i        <= w.tick.seq;
    tick_symbol_i     <= w.tick.symbol;
    tick_price_bits_i <= w.tick.price_bits;
    tick_time_i       <= w.tick.stamp;
    range_start_i     <= w.r_start;
    range_end_i       <= w.r_end;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // Word taken at this edge: advance the shadow ring
    replay_for(w);
    if (w.cmd == rrr_pkg::CMD_STORE) store_cnt++;
    else retx_cnt++;
    if (n_typed == FROM_MODEL) begin
      foreach (burst_replays[i]) pending_replays.insert(pending_replays.size(), burst_replays[i]);
    end else if (n_typed == 1) begin
      r.tick  = typed_tick;
      r.last  = 1'b1;
      r.trunc = 1'b0;
      pending_replays.insert(pending_replays.size(), r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Feed-like traffic: runs of rising sequences with gaps and late repairs,
  // retransmits near the head, one retransmit covering each run, some noise.
  // ---------------------------------------------------------------------------
  task automatic feed_random(input int quota);
    int          made;
    int          run_len;
    logic [63:0] base;
    logic [63:0] nxt;
    logic [63:0] seq;
    logic [63:0] rs;
    logic [63:0] re;
    made = 0;
    while (made < quota) begin
      case ($urandom_range(0, 3))
        0:       base = 64'($urandom_range(1, 3000));
        1:       base = rand64();
        2:       base = SEQ_TOP - 64'($urandom_range(0, 200));
        default: base = shadow_latest + 64'($urandom_range(1, 100));
      endcase
      // Runs longer than the burst limit give truncated bursts
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(66, 90) : $urandom_range(1, 24);
      nxt = base;
      for (int i = 0; i < run_len; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          // Late repair of an older tick pulls latest back
          seq = nxt - 64'($urandom_range(1, 30));
        end else begin
          seq = nxt;
          nxt = nxt + (($urandom_range(0, 15) == 0) ? 64'd2 : 64'd1);
        end
        issue_word(store_word(seq), FROM_MODEL, '0);
        made++;
        if ($urandom_range(0, 4) == 0) begin
          rs = shadow_latest - 64'($urandom_range(0, 40));
          re = ($urandom_range(0, 3) == 0) ? rand64() : rs + 64'($urandom_range(0, 60));
          issue_word(retx_word(rs, re), FROM_MODEL, '0);
          made++;
        end
      end
      // Ask for the whole run back
      issue_word(retx_word(base - 64'($urandom_range(0, 4)), nxt + 64'($urandom_range(0, 4))),
                 FROM_MODEL, '0);
      made++;
      if ($urandom_range(0, 3) == 0) begin
        rs = rand64();
        case ($urandom_range(0, 7))
          0, 1, 2: issue_word(store_word(rand64()), FROM_MODEL, '0);
          3, 4:    issue_word(retx_word(rs, rs + 64'($urandom_range(0, 50))), FROM_MODEL, '0);
          5, 6:    issue_word(retx_word(rs, rs - 64'($urandom_range(1, 1000))), FROM_MODEL, '0);
          default: issue_word(retx_word(rs, rand64()), FROM_MODEL, '0);
        endcase
        made++;
      end
    end
  endtask

  // One idling phase, then pause the feed until every replay is in
  task automatic run_phase(input int idle, input int stall, input bit hold_off);
    idle_pct  = idle;
    stall_pct = stall;
    if (hold_off) hold_asks++;
    feed_random(ITEMS_PER_PHASE);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_replays.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall at random, or hold off for a long stretch on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_taken != hold_asks) begin
      hold_taken  <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each taken output word with the oldest pending replay
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s expected %h got %h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replays.size() == 0) begin
        $error("replayed word with seq %h while nothing is pending", out_seq_o);
        mismatch_cnt++;
      end else begin
        due_replay = pending_replays.pop_front();
        checked_cnt++;
        if (due_replay.trunc) trunc_cnt++;
        check_field("out_seq", due_replay.tick.seq, out_seq_o);
        check_field("out_symbol", 64'(due_replay.tick.symbol), 64'(out_symbol_o));
        check_field("out_price_bits", due_replay.tick.price_bits, out_price_bits_o);
        check_field("out_time", due_replay.tick.stamp, out_time_o);
        check_field("last", 64'(due_replay.last), 64'(last_o));
        check_field("truncated", 64'(due_replay.trunc), 64'(truncated_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table, four random phases, drain
  // ---------------------------------------------------------------------------
  initial begin
    rrr_pkg::tick_t t_none;
    rrr_pkg::tick_t t_seq0;
    rrr_pkg::tick_t t_one;
    rrr_pkg::tick_t t_two;
    rrr_pkg::tick_t t_three;
    rrr_pkg::tick_t t_five;
    rrr_pkg::tick_t t_two_late;
    rrr_pkg::tick_t t_wrap;
    rrr_pkg::tick_t t_top;
    rrr_pkg::tick_t t_below;
    foreach (shadow_ring[i]) shadow_ring[i] = '0;
    shadow_latest = '0;

    t_none     = '0;
    t_seq0     = '{64'd0, 32'h1234_5678, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210};
    t_one      = '{64'd1, 32'hA5A5_A5A5, 64'h4059_0000_0000_0000, 64'h0000_0001_0000_0000};
    t_two      = '{64'd2, 32'h0000_0001, 64'h8000_0000_0000_0001, 64'h0000_0000_0000_0002};
    t_three    = '{64'd3, 32'h5A5A_5A5A, 64'h3FF0_0000_0000_0000, 64'h0000_0000_0000_0003};
    t_five     = '{64'd5, 32'h0BAD_F00D, 64'hC000_0000_0000_0005, 64'h0000_0000_0000_0005};
    t_two_late = '{64'd2, 32'hCAFE_0002, 64'h7FF0_0000_0000_0000, 64'h0000_0000_0000_0022};
    t_wrap     = '{64'(RING_DEPTH + 1), 32'h0000_4001, 64'h1234_0000_0000_4001, 64'h4001};
    t_top      = '{SEQ_TOP, 32'hFFFF_FFFF, SEQ_TOP, SEQ_TOP};
    t_below    = '{SEQ_TOP - 64'd1, 32'h0, 64'h0, 64'h0};

    // Empty ring right after reset: nothing to replay
    add_row(rrr_pkg::CMD_RETX,  t_none,     64'd0,   SEQ_TOP, 0, t_none);
    // Sequence zero is written but never served
    add_row(rrr_pkg::CMD_STORE, t_seq0,     SEQ_TOP, 64'd0,   0, t_none);
    add_row(rrr_pkg::CMD_RETX,  t_none,     64'd0,   64'd0,   0, t_none);
    // Range end past latest clips to latest
    add_row(rrr_pkg::CMD_STORE, t_one,      64'd7,   64'd3,   0, t_none);
    add_row(rrr_pkg::CMD_RETX,  t_none,     64'd0,   64'd5,   1, t_one);
    add_row(rrr_pkg::CMD_STORE, t_two,      64'd0,   64'd0,   0, t_none);
    add_row(rrr_pkg::CMD_STORE, t_three,    64'd0,   64'd0,   0, t_none);
    // Inverted range
    add_row(rrr_pkg::CMD_RETX,  t_none,     64'd3,   64'd1,   0, t_none);
    add_row(rrr_pkg::CMD_RETX,  t_none,     64'd1,   64'd3,   FROM_MODEL, t_none);
    // Gap at four is skipped
    add_row(rrr_pkg::CMD_STORE, t_five,     64'd0,   64'd0,   0, t_none);
    add_row(rrr_pkg::CMD_RETX,  t_none,     64'd1,   64'd10,  FROM_MODEL, t_none);
    // Older store pulls latest back
    add_row(rrr_pkg::CMD_STORE, t_two_late, 64'd0,   64'd0,   0, t_none);
    add_row(rrr_pkg::CMD_RETX,  t_none,     64'd1,   64'd10,  FROM_MODEL, t_none);
    // Wrap onto slot one; sequence one falls out of the window
    add_row(rrr_pkg::CMD_STORE, t_wrap,     64'd0,   64'd0,   0, t_none);
    add_row(rrr_pkg::CMD_RETX,  t_none,     64'd1,   64'(RING_DEPTH + 1), FROM_MODEL, t_none);
    add_row(rrr_pkg::CMD_RETX,  t_none,     64'd1,   64'd1,   0, t_none);
    // Top of the sequence space, all-ones and all-zeros payloads
    add_row(rrr_pkg::CMD_STORE, t_top,      64'd0,   64'd0,   0, t_none);
    add_row(rrr_pkg::CMD_RETX,  t_none,     SEQ_TOP, SEQ_TOP, 1, t_top);
    add_row(rrr_pkg::CMD_RETX,  t_none,     64'd0,   SEQ_TOP, FROM_MODEL, t_none);
    add_row(rrr_pkg::CMD_STORE, t_below,    SEQ_TOP, SEQ_TOP, 0, t_none);
    add_row(rrr_pkg::CMD_RETX,  t_none,     SEQ_TOP, SEQ_TOP, 0, t_none);
    add_row(rrr_pkg::CMD_RETX,  t_none,     SEQ_TOP - 64'd1, SEQ_TOP, 1, t_below);

    // Hold reset, release it at an edge; the unit then clears its ring
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) issue_word(dir_rows[i].word, dir_rows[i].n_typed, dir_rows[i].typed_tick);

    // No idling, with one long output hold-off that backs up the input
    run_phase(0, 0, 1'b1);
    run_phase(48, 0, 1'b0);
    run_phase(0, 48, 1'b0);
    run_phase(32, 32, 1'b0);

    // Let a trailing full-window scan finish so stray replays show up
    repeat (2 * RING_DEPTH + 8 * MAX_BURST) @(posedge clk_i);

    $display("tb: %0d stores and %0d retransmit requests, %0d replayed ticks checked",
             store_cnt, retx_cnt, checked_cnt);
    $display("tb: %0d bursts cut by the burst limit, %0d mismatches", trunc_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_replays.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far above a run where every request scans the whole window
  initial begin
    #(64'd2_000_000_000);
    $display("tb: FAIL");
    $finish;
  end

endmodule
